@@ src/allocation_tracker_table_macros.svh @@
// ----------------------------------------------------------------------------
// Allocation tracker table assertion macros
// Shared assertion wrappers, clocked on clk; ATT_ASSERT is quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef ALLOCATION_TRACKER_TABLE_MACROS_SVH
`define ALLOCATION_TRACKER_TABLE_MACROS_SVH

// clocked assertion, disabled during reset
`define ATT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ATT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/att_pkg.sv @@
// ----------------------------------------------------------------------------
// Allocation tracker table package
// Sequencer states, status codes, operation codes and result flags.
// ----------------------------------------------------------------------------
`default_nettype none

package att_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_SCAN,
    ST_DONE
  } att_state_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } att_status_t;

  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    att_status_t status;
    logic        found;
  } att_flags_t;

endpackage

`default_nettype wire

@@ src/att_ram.sv @@
// ----------------------------------------------------------------------------
// Allocation tracker RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module att_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/att_ctrl.sv @@
// ----------------------------------------------------------------------------
// Allocation tracker sequencer
// Walks the entry memory: search for release, close the gap, scan for the
// largest block. Physical slot count-1 holds the newest entry.
// ----------------------------------------------------------------------------
`default_nettype none

`include "allocation_tracker_table_macros.svh"

module att_ctrl #(
  parameter int TABLE_DEPTH   = 16,
  parameter int ADDRESS_WIDTH = 48,
  parameter int SIZE_WIDTH    = 32,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int TW = SIZE_WIDTH + $clog2(TABLE_DEPTH),
  localparam int EW = ADDRESS_WIDTH + SIZE_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     in_op,
  input  wire logic [ADDRESS_WIDTH-1:0] in_address,
  input  wire logic [SIZE_WIDTH-1:0]    in_size,
  output      logic                     res_valid,
  input  wire logic                     res_ready,
  output      att_pkg::att_flags_t      res_flags,
  output      logic [TW-1:0]            res_total,
  output      logic [CW-1:0]            res_count,
  output      logic [ADDRESS_WIDTH-1:0] res_address,
  output      logic [SIZE_WIDTH-1:0]    res_size,
  output      logic                     ram_we,
  output      logic [IW-1:0]            ram_waddr,
  output      logic [EW-1:0]            ram_wdata,
  output      logic [IW-1:0]            ram_raddr,
  input  wire logic [EW-1:0]            ram_rdata
);

  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  att_pkg::att_state_t  state, state_next;
  att_pkg::att_status_t status, status_next;
  logic [CW-1:0]            count, count_next;
  logic [TW-1:0]            total, total_next;
  logic [CW-1:0]            ptr, ptr_next;
  logic                     pend, pend_next;
  logic [IW-1:0]            pidx, pidx_next;
  logic [ADDRESS_WIDTH-1:0] req_addr, req_addr_next;
  logic [ADDRESS_WIDTH-1:0] best_addr, best_addr_next;
  logic [SIZE_WIDTH-1:0]    best_size, best_size_next;
  logic                     found, found_next;

  logic [ADDRESS_WIDTH-1:0] rd_addr;
  logic [SIZE_WIDTH-1:0]    rd_size;

  assign rd_addr = ram_rdata[EW-1:SIZE_WIDTH];
  assign rd_size = ram_rdata[SIZE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= att_pkg::ST_IDLE;
      count <= '0;
      total <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    ptr       <= ptr_next;
    pidx      <= pidx_next;
    req_addr  <= req_addr_next;
    best_addr <= best_addr_next;
    best_size <= best_size_next;
    found     <= found_next;
  end

  always_comb begin
    state_next     = state;
    status_next    = status;
    count_next     = count;
    total_next     = total;
    ptr_next       = ptr;
    pend_next      = pend;
    pidx_next      = pidx;
    req_addr_next  = req_addr;
    best_addr_next = best_addr;
    best_size_next = best_size;
    found_next     = found;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count[IW-1:0];
    ram_wdata      = {in_address, in_size};
    ram_raddr      = '0;

    case (state)
      att_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_addr_next  = in_address;
          best_addr_next = '0;
          best_size_next = '0;
          found_next     = 1'b0;
          pend_next      = 1'b0;
          status_next    = att_pkg::STATUS_OK;
          if (in_op == att_pkg::OP_RECORD) begin
            state_next = att_pkg::ST_SCAN;
            ptr_next   = count;
            if (count == FULL_COUNT) begin
              status_next = att_pkg::STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              count_next = count + 1'b1;
              total_next = total + TW'(in_size);
              ptr_next   = count + 1'b1;
            end
          end else begin
            state_next = att_pkg::ST_FIND;
            ptr_next   = count;
          end
        end
      end
      att_pkg::ST_FIND: begin
        if (pend && rd_addr == req_addr) begin
          total_next = total - TW'(rd_size);
          ptr_next   = CW'(pidx) + 1'b1;
          pend_next  = 1'b0;
          state_next = att_pkg::ST_SHIFT;
        end else if (ptr == '0) begin
          status_next = att_pkg::STATUS_NOT_FOUND;
          ptr_next    = count;
          pend_next   = 1'b0;
          state_next  = att_pkg::ST_SCAN;
        end else begin
          ram_raddr = ptr[IW-1:0] - 1'b1;
          pend_next = 1'b1;
          pidx_next = ptr[IW-1:0] - 1'b1;
          ptr_next  = ptr - 1'b1;
        end
      end
      att_pkg::ST_SHIFT: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pidx - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (ptr != count) begin
          ram_raddr = ptr[IW-1:0];
          pend_next = 1'b1;
          pidx_next = ptr[IW-1:0];
          ptr_next  = ptr + 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - 1'b1;
            ptr_next   = count - 1'b1;
            state_next = att_pkg::ST_SCAN;
          end
        end
      end
      att_pkg::ST_SCAN: begin
        // strict compare, newest first: ties keep the newer entry
        if (pend && rd_size > best_size) begin
          best_size_next = rd_size;
          best_addr_next = rd_addr;
          found_next     = 1'b1;
        end
        if (ptr != '0) begin
          ram_raddr = ptr[IW-1:0] - 1'b1;
          pend_next = 1'b1;
          pidx_next = ptr[IW-1:0] - 1'b1;
          ptr_next  = ptr - 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = att_pkg::ST_DONE;
          end
        end
      end
      att_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = att_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = att_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_flags.status = status;
  assign res_flags.found  = found;
  assign res_total        = total;
  assign res_count        = count;
  assign res_address      = best_addr;
  assign res_size         = best_size;

  `ATT_ASSERT(a_count_range, count <= FULL_COUNT, "live count above table depth")
  `ATT_ASSERT(a_record_grows,
    (state == att_pkg::ST_IDLE && in_valid && in_op == att_pkg::OP_RECORD &&
     count != FULL_COUNT) |=> (count == $past(count) + 1'b1),
    "accepted record did not add an entry")
  `ATT_ASSERT(a_release_shrinks,
    (state == att_pkg::ST_SCAN && $past(state) == att_pkg::ST_SHIFT) |->
    (count == $past(count) - 1'b1),
    "release did not remove exactly one entry")
  `ATT_ASSERT(a_write_phase,
    ram_we |-> (state == att_pkg::ST_IDLE || state == att_pkg::ST_SHIFT),
    "entry memory written outside record or compaction")

endmodule

`default_nettype wire

@@ src/allocation_tracker_table.sv @@
// ----------------------------------------------------------------------------
// Allocation tracker table
// Live allocation table with record/release and largest-block reporting.
// ----------------------------------------------------------------------------
// One item is handled at a time, and every item returns one result. All
// work goes through the single read port of the entry memory, one entry per
// cycle. A record writes its entry as it is accepted, unless the table is
// full, and then scans the live entries for the largest block. A release
// that finds its address searches from the newest entry, compacts the
// entries newer than the hit, then runs the largest-block scan. A release
// that misses searches every entry, then scans. The result is held while
// the output register is still full. A new item is taken while the last
// result still waits in the output register.
`default_nettype none

module allocation_tracker_table #(
  parameter int TABLE_DEPTH   = 16,
  parameter int ADDRESS_WIDTH = 48,
  parameter int SIZE_WIDTH    = 32,
  localparam int CW     = $clog2(TABLE_DEPTH + 1),
  localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int TW     = SIZE_WIDTH + $clog2(TABLE_DEPTH),
  localparam int EW     = ADDRESS_WIDTH + SIZE_WIDTH,
  localparam int IN_DW  = ((EW + 7) / 8) * 8,
  localparam int OUT_RW = TW + CW + 1 + ADDRESS_WIDTH + SIZE_WIDTH,
  localparam int OUT_DW = ((OUT_RW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  // address, size
  input  wire logic [IN_DW-1:0]  s_axis_tdata,
  // operation
  input  wire logic [0:0]        s_axis_tuser,
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // total_bytes, live_count, largest_found, largest_address, largest_size
  output      logic [OUT_DW-1:0] m_axis_tdata,
  // status
  output      logic [1:0]        m_axis_tuser
);

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic [IW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;

  logic                     res_valid;
  logic                     res_ready;
  att_pkg::att_flags_t      res_flags;
  logic [TW-1:0]            res_total;
  logic [CW-1:0]            res_count;
  logic [ADDRESS_WIDTH-1:0] res_address;
  logic [SIZE_WIDTH-1:0]    res_size;

  att_pkg::att_flags_t      out_flags;
  logic [TW-1:0]            out_total;
  logic [CW-1:0]            out_count;
  logic [ADDRESS_WIDTH-1:0] out_address;
  logic [SIZE_WIDTH-1:0]    out_size;
  logic                     out_valid;

  att_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  att_ctrl #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .SIZE_WIDTH    (SIZE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser[0]),
    .in_address  (s_axis_tdata[ADDRESS_WIDTH-1:0]),
    .in_size     (s_axis_tdata[EW-1:ADDRESS_WIDTH]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_flags   (res_flags),
    .res_total   (res_total),
    .res_count   (res_count),
    .res_address (res_address),
    .res_size    (res_size),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_flags   <= res_flags;
      out_total   <= res_total;
      out_count   <= res_count;
      out_address <= res_address;
      out_size    <= res_size;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DW'({out_size, out_address, out_flags.found, out_count, out_total});
  assign m_axis_tuser  = out_flags.status;

endmodule

`default_nettype wire
